[rtl/dbd_pkg.sv]
// ============================================================================
// dbd_pkg: shared definitions for the detection box decoder
// Widths, register map, reset values and the structures passed between the
// configuration block, the row accumulator and the box arithmetic.
// ============================================================================
`default_nettype none

package dbd_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int BOX_FIELDS = 5;

	localparam int DATA_W  = 32;
	localparam int THR_W   = 17;
	localparam int SCALE_W = 23;
	localparam int CLASS_W = 8;
	localparam int POS_W   = 9;
	localparam int SCORE_W = 31;
	localparam int ADDR_W  = 4;
	localparam int APB_W   = 32;

	localparam int EDGE_SUM_W   = DATA_W + 1;
	localparam int EDGE_PROD_W  = EDGE_SUM_W + SCALE_W + 1;
	localparam int EDGE_SH_W    = EDGE_PROD_W - FRAC_BITS;
	localparam int SCORE_PROD_W = 2 * DATA_W;

	localparam logic [1:0] REG_MIN_SCORE   = 2'd0;
	localparam logic [1:0] REG_X_SCALE     = 2'd1;
	localparam logic [1:0] REG_Y_SCALE     = 2'd2;
	localparam logic [1:0] REG_CLASS_COUNT = 2'd3;

	localparam logic [THR_W-1:0]   RST_MIN_SCORE   = THR_W'(16384);
	localparam logic [SCALE_W-1:0] RST_X_SCALE     = SCALE_W'(65536);
	localparam logic [SCALE_W-1:0] RST_Y_SCALE     = SCALE_W'(65536);
	localparam logic [CLASS_W-1:0] RST_CLASS_COUNT = CLASS_W'(80);

	typedef struct packed {
		logic [THR_W-1:0]   min_score;
		logic [SCALE_W-1:0] x_scale;
		logic [SCALE_W-1:0] y_scale;
		logic [CLASS_W-1:0] class_count;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] centre_x;
		logic signed [DATA_W-1:0] centre_y;
		logic signed [DATA_W-1:0] box_width;
		logic signed [DATA_W-1:0] box_height;
		logic signed [DATA_W-1:0] objectness;
		logic signed [DATA_W-1:0] best_class_score;
		logic [CLASS_W-1:0]       best_class_index;
	} row_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] left_x;
		logic signed [DATA_W-1:0] top_y;
		logic signed [DATA_W-1:0] right_x;
		logic signed [DATA_W-1:0] bottom_y;
		logic [SCORE_W-1:0]       score;
		logic [CLASS_W-1:0]       class_label;
	} det_t;

endpackage

`default_nettype wire

[rtl/dbd_element_if.sv]
// ============================================================================
// dbd_element_if: prediction element channel
// Carries one signed Q16.16 element of a prediction row per request.
// ============================================================================
`default_nettype none

interface dbd_element_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dbd_pkg::DATA_W-1:0]    element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

`default_nettype wire

[rtl/dbd_detection_if.sv]
// ============================================================================
// dbd_detection_if: detection result channel
// Carries one corner box with its score and class label per request.
// ============================================================================
`default_nettype none

interface dbd_detection_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [dbd_pkg::DATA_W-1:0]    left_x;
	logic signed [dbd_pkg::DATA_W-1:0]    top_y;
	logic signed [dbd_pkg::DATA_W-1:0]    right_x;
	logic signed [dbd_pkg::DATA_W-1:0]    bottom_y;
	logic [dbd_pkg::SCORE_W-1:0]          score;
	logic [dbd_pkg::CLASS_W-1:0]          class_label;

	modport source (output valid, output left_x, output top_y, output right_x,
		output bottom_y, output score, output class_label, input ready);
	modport sink (input valid, input left_x, input top_y, input right_x,
		input bottom_y, input score, input class_label, output ready);
endinterface

`default_nettype wire

[rtl/dbd_cfg.sv]
// ============================================================================
// dbd_cfg: configuration registers
// APB-style register file holding threshold, scale factors and class count.
// ============================================================================
`default_nettype none

module dbd_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dbd_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [dbd_pkg::APB_W-1:0]    pwdata,
	output logic      [dbd_pkg::APB_W-1:0]    prdata,
	output logic                              pready,
	output dbd_pkg::cfg_t                     cfg
);

	dbd_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_score   <= dbd_pkg::RST_MIN_SCORE;
			cfg_q.x_scale     <= dbd_pkg::RST_X_SCALE;
			cfg_q.y_scale     <= dbd_pkg::RST_Y_SCALE;
			cfg_q.class_count <= dbd_pkg::RST_CLASS_COUNT;
		end else if (wr_en) begin
			case (reg_sel)
				dbd_pkg::REG_MIN_SCORE: begin
					cfg_q.min_score <= pwdata[dbd_pkg::THR_W-1:0];
				end
				dbd_pkg::REG_X_SCALE: begin
					cfg_q.x_scale <= pwdata[dbd_pkg::SCALE_W-1:0];
				end
				dbd_pkg::REG_Y_SCALE: begin
					cfg_q.y_scale <= pwdata[dbd_pkg::SCALE_W-1:0];
				end
				dbd_pkg::REG_CLASS_COUNT: begin
					cfg_q.class_count <= pwdata[dbd_pkg::CLASS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			dbd_pkg::REG_MIN_SCORE:   prdata = dbd_pkg::APB_W'(cfg_q.min_score);
			dbd_pkg::REG_X_SCALE:     prdata = dbd_pkg::APB_W'(cfg_q.x_scale);
			dbd_pkg::REG_Y_SCALE:     prdata = dbd_pkg::APB_W'(cfg_q.y_scale);
			dbd_pkg::REG_CLASS_COUNT: prdata = dbd_pkg::APB_W'(cfg_q.class_count);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/dbd_row.sv]
// ============================================================================
// dbd_row: prediction row accumulator
// Tracks the position in the row, keeps the box fields and a running argmax
// over the class scores, and captures the finished row on its last element.
// ============================================================================
`default_nettype none

module dbd_row (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              advance,
	input  wire logic                              accept,
	input  wire logic signed [dbd_pkg::DATA_W-1:0] element_value,
	input  wire logic [dbd_pkg::CLASS_W-1:0]       class_count,
	output logic                                   valid_s1,
	output dbd_pkg::row_t                          row_s1
);

	dbd_pkg::row_t               row_q;
	dbd_pkg::row_t               row_n;
	logic [dbd_pkg::POS_W-1:0]   pos_q;
	logic [dbd_pkg::POS_W-1:0]   last_pos;
	logic [dbd_pkg::POS_W-1:0]   class_offset;
	logic [dbd_pkg::CLASS_W-1:0] classes;
	logic                        is_last;

	assign classes      = (class_count == '0) ? dbd_pkg::CLASS_W'(1) : class_count;
	assign last_pos     = dbd_pkg::POS_W'(classes) + dbd_pkg::POS_W'(dbd_pkg::BOX_FIELDS - 1);
	assign is_last      = pos_q >= last_pos;
	assign class_offset = pos_q - dbd_pkg::POS_W'(dbd_pkg::BOX_FIELDS);

	always_comb begin
		row_n = row_q;
		case (pos_q)
			dbd_pkg::POS_W'(0): row_n.centre_x   = element_value;
			dbd_pkg::POS_W'(1): row_n.centre_y   = element_value;
			dbd_pkg::POS_W'(2): row_n.box_width  = element_value;
			dbd_pkg::POS_W'(3): row_n.box_height = element_value;
			dbd_pkg::POS_W'(4): row_n.objectness = element_value;
			dbd_pkg::POS_W'(dbd_pkg::BOX_FIELDS): begin
				row_n.best_class_score = element_value;
				row_n.best_class_index = '0;
			end
			default: begin
				if (element_value > row_q.best_class_score) begin
					row_n.best_class_score = element_value;
					row_n.best_class_index = class_offset[dbd_pkg::CLASS_W-1:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && is_last;
			if (accept) begin
				row_q <= row_n;
				pos_q <= is_last ? '0 : pos_q + dbd_pkg::POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && accept && is_last) begin
			row_s1 <= row_n;
		end
	end

endmodule

`default_nettype wire

[rtl/dbd_calc.sv]
// ============================================================================
// dbd_calc: box and score arithmetic
// Forms scaled corner edges and the combined score in a multiply stage, then
// rounds down, saturates and applies the threshold into the result register.
// ============================================================================
`default_nettype none

module dbd_calc (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire logic          valid_s1,
	input  dbd_pkg::row_t      row_s1,
	input  dbd_pkg::cfg_t      cfg,
	output logic               det_valid_q,
	output dbd_pkg::det_t      det_q
);

	localparam int EW = dbd_pkg::EDGE_SUM_W;
	localparam int PW = dbd_pkg::EDGE_PROD_W;
	localparam int SW = dbd_pkg::EDGE_SH_W;
	localparam int QW = dbd_pkg::SCORE_PROD_W;
	localparam int DW = dbd_pkg::DATA_W;

	function automatic logic signed [DW-1:0] sat_word(input logic signed [SW-1:0] v);
		logic [SW-DW:0] upper;
		upper = v[SW-1:DW-1];
		if (&upper || ~|upper) begin
			sat_word = v[DW-1:0];
		end else if (v[SW-1]) begin
			sat_word = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat_word = {1'b0, {(DW-1){1'b1}}};
		end
	endfunction

	logic signed [DW-1:0] half_w;
	logic signed [DW-1:0] half_h;
	logic signed [EW-1:0] sum_left;
	logic signed [EW-1:0] sum_top;
	logic signed [EW-1:0] sum_right;
	logic signed [EW-1:0] sum_bottom;
	logic signed [dbd_pkg::SCALE_W:0] scale_w;
	logic signed [dbd_pkg::SCALE_W:0] scale_h;

	logic signed [PW-1:0] left_s2;
	logic signed [PW-1:0] top_s2;
	logic signed [PW-1:0] right_s2;
	logic signed [PW-1:0] bottom_s2;
	logic signed [QW-1:0] score_s2;
	logic                 obj_ok_s2;
	logic [dbd_pkg::CLASS_W-1:0] label_s2;
	logic                 valid_s2;

	logic signed [PW-1:0] left_sh;
	logic signed [PW-1:0] top_sh;
	logic signed [PW-1:0] right_sh;
	logic signed [PW-1:0] bottom_sh;
	logic signed [QW-1:0] score_sh;
	logic signed [QW-1:0] thr_wide;
	logic                 score_ok;

	assign half_w     = row_s1.box_width >>> 1;
	assign half_h     = row_s1.box_height >>> 1;
	assign sum_left   = EW'(row_s1.centre_x) - EW'(half_w);
	assign sum_right  = EW'(row_s1.centre_x) + EW'(half_w);
	assign sum_top    = EW'(row_s1.centre_y) - EW'(half_h);
	assign sum_bottom = EW'(row_s1.centre_y) + EW'(half_h);
	assign scale_w    = $signed({1'b0, cfg.x_scale});
	assign scale_h    = $signed({1'b0, cfg.y_scale});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			left_s2   <= sum_left * scale_w;
			right_s2  <= sum_right * scale_w;
			top_s2    <= sum_top * scale_h;
			bottom_s2 <= sum_bottom * scale_h;
			score_s2  <= row_s1.objectness * row_s1.best_class_score;
			obj_ok_s2 <= row_s1.objectness >= $signed({{(DW-dbd_pkg::THR_W){1'b0}},
				cfg.min_score});
			label_s2  <= row_s1.best_class_index;
		end
	end

	assign left_sh   = left_s2 >>> dbd_pkg::FRAC_BITS;
	assign top_sh    = top_s2 >>> dbd_pkg::FRAC_BITS;
	assign right_sh  = right_s2 >>> dbd_pkg::FRAC_BITS;
	assign bottom_sh = bottom_s2 >>> dbd_pkg::FRAC_BITS;
	assign score_sh  = score_s2 >>> dbd_pkg::FRAC_BITS;
	assign thr_wide  = $signed({{(QW-dbd_pkg::THR_W){1'b0}}, cfg.min_score});
	assign score_ok  = score_sh >= thr_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_valid_q <= 1'b0;
		end else if (advance) begin
			det_valid_q <= valid_s2 && obj_ok_s2 && score_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			det_q.left_x      <= sat_word(left_sh[SW-1:0]);
			det_q.top_y       <= sat_word(top_sh[SW-1:0]);
			det_q.right_x     <= sat_word(right_sh[SW-1:0]);
			det_q.bottom_y    <= sat_word(bottom_sh[SW-1:0]);
			det_q.score       <= (|score_sh[QW-1:dbd_pkg::SCORE_W]) ?
				{dbd_pkg::SCORE_W{1'b1}} : score_sh[dbd_pkg::SCORE_W-1:0];
			det_q.class_label <= label_s2;
		end
	end

endmodule

`default_nettype wire

[rtl/detection_box_decoder.sv]
// ============================================================================
// detection_box_decoder: prediction row to detection box decoder
// Collects one prediction row element by element and returns a scaled corner
// box, combined score and class label for rows that pass the threshold.
//
//   channel     direction  protocol       payload
//   element     in         valid/ready    element_value
//   detection   out        valid/ready    left_x top_y right_x bottom_y
//                                         score class_label
//   config      in         APB write/read threshold, scales, class count
//
// One element is taken every cycle while the pipeline does not stall; a row
// holds 5 + class_count elements, or 6 when class_count is zero. The edge
// that takes the row's last element captures the row; a multiply stage and a
// rounding and threshold stage follow before the detection is valid.
// The pipeline stalls as a whole only while a detection waits to be taken.
// Reset clears the row position and the pipeline valid flags.
// ============================================================================
`default_nettype none

module detection_box_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dbd_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [dbd_pkg::APB_W-1:0]     pwdata,
	output logic      [dbd_pkg::APB_W-1:0]     prdata,
	output logic                               pready,
	dbd_element_if.sink                        element,
	dbd_detection_if.source                    detection
);

	dbd_pkg::cfg_t cfg;
	dbd_pkg::row_t row_s1;
	dbd_pkg::det_t det_q;
	logic          valid_s1;
	logic          det_valid_q;
	logic          advance;
	logic          accept;

	assign advance       = !det_valid_q || detection.ready;
	assign element.ready = advance;
	assign accept        = element.valid && advance;

	dbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dbd_row u_row (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.accept        (accept),
		.element_value (element.element_value),
		.class_count   (cfg.class_count),
		.valid_s1      (valid_s1),
		.row_s1        (row_s1)
	);

	dbd_calc u_calc (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.row_s1      (row_s1),
		.cfg         (cfg),
		.det_valid_q (det_valid_q),
		.det_q       (det_q)
	);

	assign detection.valid       = det_valid_q;
	assign detection.left_x      = det_q.left_x;
	assign detection.top_y       = det_q.top_y;
	assign detection.right_x     = det_q.right_x;
	assign detection.bottom_y    = det_q.bottom_y;
	assign detection.score       = det_q.score;
	assign detection.class_label = det_q.class_label;

endmodule

`default_nettype wire
